FILE: rtl/dtps_pkg.sv
// ----------------------------------------------------------------------------
// dtps_pkg
// Shared types and constants of the dual-tap pitch shifter: sample format,
// Q16 phase limits, delay buffer geometry and the register map.
// ----------------------------------------------------------------------------
package dtps_pkg;

   // sample format
   localparam int SAMPLE_W = 16;
   typedef logic signed [SAMPLE_W-1:0] sample_type;

   // delay buffer geometry (power-of-two depth)
   localparam int BUF_DEPTH = 1024;
   localparam int BUF_AW    = $clog2(BUF_DEPTH);
   localparam int FRAC_W    = 16;
   localparam int POS_W     = BUF_AW + FRAC_W;

   // Q16 phase limits
   localparam int ONE_Q16    = 65536;
   localparam int PHASE_W    = 26;
   localparam int PHASE_LOW  = 12 * ONE_Q16;
   localparam int PHASE_HIGH = 1012 * ONE_Q16;
   localparam int PHASE_SPAN = 1000 * ONE_Q16;
   localparam int PHASE_MID  = 512 * ONE_Q16;
   localparam int TAP_OFFSET = 500 * ONE_Q16;

   // envelope: |d0 - mid| / 500 = (|d0 - mid| >> 2) / 125 by reciprocal
   localparam int ENV_W       = 17;
   localparam int ENV_Q_W     = 23;
   localparam int ENV_DIVISOR = 125;
   localparam int DIV_SHIFT   = 24;
   localparam int DIV_RECIP   = (1 << DIV_SHIFT) / ENV_DIVISOR;

   // shared multiplier operand widths
   localparam int MUL_A_W = 34;
   localparam int MUL_B_W = 19;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   // configuration registers
   localparam int RATIO_W     = 18;
   localparam int MIX_W       = 17;
   localparam int MIX_RESET   = 32768;
   localparam int CSR_AW      = 3;
   localparam int CSR_DW      = 32;
   localparam logic CSR_SHIFT_RATIO = 1'b0;
   localparam logic CSR_EFFECT_MIX  = 1'b1;

endpackage

FILE: rtl/dtps_if.sv
// ----------------------------------------------------------------------------
// dtps_if
// Valid/ready channels of the pitch shifter: input samples and results.
// ----------------------------------------------------------------------------
interface dtps_req_if;
   logic                 valid;
   logic                 ready;
   dtps_pkg::sample_type sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink (input valid, input sample_in, output ready);
endinterface

interface dtps_rsp_if;
   logic                 valid;
   logic                 ready;
   dtps_pkg::sample_type sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink (input valid, input sample_out, output ready);
endinterface

FILE: rtl/dual_tap_pitch_shifter.sv
// ----------------------------------------------------------------------------
// dual_tap_pitch_shifter
// Delay-line pitch shifter: two interpolated taps 500 samples apart,
// crossfaded by a triangular envelope and mixed with the dry input.
// ----------------------------------------------------------------------------
// One sample at a time: a new input is taken only in IDLE, after the result
//   of the last one is registered. One shared multiplier is used five times
//   and one buffer port is read four times per sample.
// Reset (synchronous): phase 12.0, write pointer 0, buffer reads as zero until
//   each entry is first written (fill flag), no clearing pass.
module dual_tap_pitch_shifter (
   input  logic                          clock,
   input  logic                          reset,
   dtps_req_if.sink                      req,
   dtps_rsp_if.source                    rsp,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [dtps_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [dtps_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [dtps_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);

   // sequencer codes
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_PHASE = 4'd1;
   localparam logic [3:0] ST_RD0   = 4'd2;
   localparam logic [3:0] ST_RD1   = 4'd3;
   localparam logic [3:0] ST_RD2   = 4'd4;
   localparam logic [3:0] ST_RD3   = 4'd5;
   localparam logic [3:0] ST_TAP1  = 4'd6;
   localparam logic [3:0] ST_TAP1B = 4'd7;
   localparam logic [3:0] ST_ENV   = 4'd8;
   localparam logic [3:0] ST_WET   = 4'd9;
   localparam logic [3:0] ST_MIX   = 4'd10;
   localparam logic [3:0] ST_DONE  = 4'd11;

   localparam int AW  = dtps_pkg::BUF_AW;
   localparam int FW  = dtps_pkg::FRAC_W;
   localparam int PW  = dtps_pkg::POS_W;
   localparam int PHW = dtps_pkg::PHASE_W;

   // control and configuration state
   logic [3:0]                      state_ff, state_in;
   logic [PHW-1:0]                  phase_ff;
   logic [dtps_pkg::RATIO_W-1:0]    ratio_ff;
   logic [dtps_pkg::MIX_W-1:0]      mix_ff;
   logic [AW-1:0]                   wp_ff;
   logic                            wrapped_ff;
   logic                            rsp_valid_ff;

   // datapath registers
   dtps_pkg::sample_type            x_ff, b0_ff, c0_ff, rd_ff, rsp_data_ff, rsp_data_in;
   logic                            rd_ok_ff;
   logic [PW-1:0]                   pos0_ff, pos1_ff;
   logic [dtps_pkg::ENV_Q_W-1:0]    q_ff;
   logic [dtps_pkg::ENV_W-1:0]      env1_ff, env1_in;
   logic signed [31:0]              tap0_ff, tap1_ff, wet_ff;
   logic signed [dtps_pkg::PROD_W-1:0] prod_ff;

   // buffer memory
   dtps_pkg::sample_type            mem [dtps_pkg::BUF_DEPTH];

   logic csr_wr, accept, finish;

   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign accept     = req.valid && req.ready;
   assign req.ready  = (state_ff == ST_IDLE);
   assign finish     = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp.ready);
   assign rsp.valid  = rsp_valid_ff;
   assign rsp.sample_out = rsp_data_ff;

   // register readback
   always_comb begin
      case (csr_paddr[2])
         dtps_pkg::CSR_SHIFT_RATIO:
            csr_prdata = {{(dtps_pkg::CSR_DW-dtps_pkg::RATIO_W){1'b0}}, ratio_ff};
         default:
            csr_prdata = {{(dtps_pkg::CSR_DW-dtps_pkg::MIX_W){1'b0}}, mix_ff};
      endcase
   end

   // phase advance and wrap, second tap, envelope numerator, read positions
   logic signed [18:0]   rate;
   logic signed [27:0]   sum0;
   logic [PHW-1:0]       d0, d1;
   logic [PHW:0]         sum1;
   logic signed [PHW:0]  dm;
   logic [24:0]          dabs;

   always_comb begin
      rate = $signed(19'(dtps_pkg::ONE_Q16)) - $signed({1'b0, ratio_ff});
      sum0 = $signed({2'b00, phase_ff}) + $signed({{9{rate[18]}}, rate});
      if (sum0 > $signed(28'(dtps_pkg::PHASE_HIGH))) begin
         d0 = PHW'(sum0 - $signed(28'(dtps_pkg::PHASE_SPAN)));
      end else if (sum0 < $signed(28'(dtps_pkg::PHASE_LOW))) begin
         d0 = PHW'(sum0 + $signed(28'(dtps_pkg::PHASE_SPAN)));
      end else begin
         d0 = PHW'(sum0);
      end
      sum1 = {1'b0, d0} + (PHW+1)'(dtps_pkg::TAP_OFFSET);
      if (sum1 > (PHW+1)'(dtps_pkg::PHASE_HIGH)) begin
         d1 = PHW'(sum1 - (PHW+1)'(dtps_pkg::PHASE_SPAN));
      end else begin
         d1 = sum1[PHW-1:0];
      end
      dm   = $signed({1'b0, d0}) - $signed((PHW+1)'(dtps_pkg::PHASE_MID));
      dabs = dm[PHW] ? 25'(-dm) : 25'(dm);
   end

   // envelope quotient correction: estimate is exact or one low
   logic [dtps_pkg::ENV_W-1:0] est;
   logic [23:0]                est125, rem;

   always_comb begin
      est    = prod_ff[dtps_pkg::DIV_SHIFT+dtps_pkg::ENV_W-1:dtps_pkg::DIV_SHIFT];
      est125 = 24'({est, 7'b0}) - 24'({est, 2'b0}) + 24'(est);
      rem    = {1'b0, q_ff} - est125;
      env1_in = (rem >= 24'(dtps_pkg::ENV_DIVISOR)) ? est + 1'b1 : est;
   end

   // buffer read address per sequencer step
   logic [AW-1:0]        rd_addr;
   dtps_pkg::sample_type rdv;

   always_comb begin
      case (state_ff)
         ST_RD0:  rd_addr = pos0_ff[PW-1:FW];
         ST_RD1:  rd_addr = pos0_ff[PW-1:FW] + 1'b1;
         ST_RD2:  rd_addr = pos1_ff[PW-1:FW];
         ST_RD3:  rd_addr = pos1_ff[PW-1:FW] + 1'b1;
         default: rd_addr = wp_ff;
      endcase
   end

   // entries not yet written since reset read as zero
   assign rdv = rd_ok_ff ? rd_ff : '0;

   // shared multiplier operand selection
   logic signed [dtps_pkg::MUL_A_W-1:0] mul_a;
   logic signed [dtps_pkg::MUL_B_W-1:0] mul_b;
   logic signed [dtps_pkg::PROD_W-1:0]  prod;
   logic signed [16:0]                  sdiff;
   logic signed [32:0]                  tdiff, mdiff;
   logic                                mul_en;

   always_comb begin
      sdiff = (state_ff == ST_TAP1) ? ({rdv[15], rdv} - {c0_ff[15], c0_ff})
                                    : ({rdv[15], rdv} - {b0_ff[15], b0_ff});
      tdiff = {tap1_ff[31], tap1_ff} - {tap0_ff[31], tap0_ff};
      mdiff = {wet_ff[31], wet_ff} - {x_ff[15], x_ff, 16'b0};
      mul_en = 1'b1;
      case (state_ff)
         ST_RD0: begin
            mul_a = $signed({{(dtps_pkg::MUL_A_W-dtps_pkg::ENV_Q_W){1'b0}}, q_ff});
            mul_b = $signed(dtps_pkg::MUL_B_W'(dtps_pkg::DIV_RECIP));
         end
         ST_RD2: begin
            mul_a = {{(dtps_pkg::MUL_A_W-17){sdiff[16]}}, sdiff};
            mul_b = $signed({3'b000, pos0_ff[FW-1:0]});
         end
         ST_TAP1: begin
            mul_a = {{(dtps_pkg::MUL_A_W-17){sdiff[16]}}, sdiff};
            mul_b = $signed({3'b000, pos1_ff[FW-1:0]});
         end
         ST_ENV: begin
            mul_a = {tdiff[32], tdiff};
            mul_b = $signed({2'b00, env1_ff});
         end
         ST_MIX: begin
            mul_a = {mdiff[32], mdiff};
            mul_b = $signed({2'b00, mix_ff});
         end
         default: begin
            mul_a  = '0;
            mul_b  = '0;
            mul_en = 1'b0;
         end
      endcase
   end

   assign prod = mul_a * mul_b;

   // tap sum, wet signal and rounded, saturated output
   logic signed [33:0]                 tsum;
   logic signed [dtps_pkg::PROD_W-1:0] rnd;
   logic signed [21:0]                 ysum;

   always_comb begin
      tsum = (state_ff == ST_TAP1B)
             ? $signed({{2{c0_ff[15]}}, c0_ff, 16'b0}) + prod_ff[33:0]
             : $signed({{2{b0_ff[15]}}, b0_ff, 16'b0}) + prod_ff[33:0];
      rnd  = prod_ff + $signed(dtps_pkg::PROD_W'(64'h8000_0000));
      ysum = {{6{x_ff[15]}}, x_ff} + {rnd[dtps_pkg::PROD_W-1], rnd[dtps_pkg::PROD_W-1:32]};
      if (ysum > 22'sd32767) begin
         rsp_data_in = 16'sh7fff;
      end else if (ysum < -22'sd32768) begin
         rsp_data_in = 16'sh8000;
      end else begin
         rsp_data_in = ysum[15:0];
      end
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_PHASE;
         ST_DONE:  if (finish) state_in = ST_IDLE;
         ST_PHASE, ST_RD0, ST_RD1, ST_RD2, ST_RD3, ST_TAP1, ST_TAP1B,
         ST_ENV, ST_WET, ST_MIX: state_in = state_ff + 1'b1;
         default:  state_in = ST_IDLE;
      endcase
   end

   // control registers, configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PHW'(dtps_pkg::PHASE_LOW);
         ratio_ff     <= '0;
         mix_ff       <= dtps_pkg::MIX_W'(dtps_pkg::MIX_RESET);
         wp_ff        <= '0;
         wrapped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr) begin
            case (csr_paddr[2])
               dtps_pkg::CSR_SHIFT_RATIO: begin
                  ratio_ff <= csr_pwdata[dtps_pkg::RATIO_W-1:0];
                  if (csr_pwdata[dtps_pkg::RATIO_W-1:0] ==
                      dtps_pkg::RATIO_W'(dtps_pkg::ONE_Q16)) begin
                     phase_ff <= PHW'(dtps_pkg::PHASE_MID);
                  end
               end
               default: mix_ff <= csr_pwdata[dtps_pkg::MIX_W-1:0];
            endcase
         end
         if (state_ff == ST_PHASE) begin
            phase_ff <= d0;
         end
         // output register: load on finish, drop after transfer
         if (finish) begin
            rsp_valid_ff <= 1'b1;
            wp_ff        <= wp_ff + 1'b1;
            if (wp_ff == AW'(dtps_pkg::BUF_DEPTH - 1)) begin
               wrapped_ff <= 1'b1;
            end
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff <= req.sample_in;
      end
      if (state_ff == ST_PHASE) begin
         pos0_ff <= {wp_ff, {FW{1'b0}}} - PW'(d0);
         pos1_ff <= {wp_ff, {FW{1'b0}}} - PW'(d1);
         q_ff    <= dabs[24:2];
      end
      if (mul_en) begin
         prod_ff <= prod;
      end
      if (state_ff == ST_RD1) begin
         b0_ff   <= rdv;
         env1_ff <= env1_in;
      end
      if (state_ff == ST_RD3) begin
         c0_ff   <= rdv;
         tap0_ff <= tsum[31:0];
      end
      if (state_ff == ST_TAP1B) begin
         tap1_ff <= tsum[31:0];
      end
      if (state_ff == ST_WET) begin
         wet_ff <= tap0_ff + $signed(prod_ff[47:16]);
      end
      if (finish) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // delay buffer: one registered read, sample write at the end of each item
   always_ff @(posedge clock) begin
      rd_ff    <= mem[rd_addr];
      rd_ok_ff <= wrapped_ff || (rd_addr < wp_ff);
      if (finish) begin
         mem[wp_ff] <= x_ff;
      end
   end

endmodule

FILE: rtl/dtps_checker.sv
// ----------------------------------------------------------------------------
// dtps_checker
// Port-level checks of the pitch shifter's channels, bound to the top level.
// ----------------------------------------------------------------------------
module dtps_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input dtps_pkg::sample_type rsp_sample_out
);

   // no result is pending right after reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_out))
      else $error("stalled result changed");

   // the sequencer is busy after an input transfer
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while busy");

   // a result never appears the cycle after an input transfer
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result too early");

endmodule

bind dual_tap_pitch_shifter dtps_checker u_dtps_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_sample_out (rsp.sample_out)
);

FILE: bench/dtps_sample_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtps_sample_check
// Watches the sample channels and the register port of the pitch shifter.
// Keeps its own copy of the delay buffer, the tap phase and the registers,
// predicts each output sample from the accepted input and compares it with
// the next result transfer. Register reads are checked against the copy.
// ----------------------------------------------------------------------------
module dtps_sample_check (
   input  logic                        clock,
   input  logic                        reset,
   dtps_req_if                         req,
   dtps_rsp_if                         rsp,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [dtps_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [dtps_pkg::CSR_DW-1:0] csr_pwdata,
   input  logic [dtps_pkg::CSR_DW-1:0] csr_prdata,
   input  logic                        csr_pready,
   output int                          fail_count,
   output int                          pending
);

   localparam longint ENV_SPAN    = 500;
   localparam longint SAT_HIGH    = 32767;
   localparam longint SAT_LOW     = -32768;
   localparam longint ROUND_HALF  = longint'(1) << 31;
   localparam int     PRINT_LIMIT = 200;

   // predictor state
   dtps_pkg::sample_type                delay_mem [dtps_pkg::BUF_DEPTH];
   logic [dtps_pkg::BUF_AW-1:0]         wr_ptr;
   logic [dtps_pkg::PHASE_W-1:0]        phase_q16;
   logic [dtps_pkg::RATIO_W-1:0]        ratio_reg;
   logic [dtps_pkg::MIX_W-1:0]          mix_reg;

   // output samples still owed by the block, oldest first
   dtps_pkg::sample_type                owed_samples [$];

   logic [dtps_pkg::CSR_AW-3:0]         reg_index;

   assign reg_index = csr_paddr[dtps_pkg::CSR_AW-1:2];

   task automatic report_mismatch(input string what, input longint got, input longint want);
      if (fail_count < PRINT_LIMIT)
         $display("mismatch at %0t ns: %s got %0d, expected %0d", $time, what, got, want);
      fail_count++;
   endtask

   // linear interpolation between two neighbors, Q16 delay behind the write pointer
   function automatic longint tap_value(input longint delay);
      longint                      pos;
      logic [dtps_pkg::BUF_AW-1:0] idx;
      logic [dtps_pkg::BUF_AW-1:0] nxt;
      logic [dtps_pkg::FRAC_W-1:0] frac;
      pos  = longint'(wr_ptr) * dtps_pkg::ONE_Q16 - delay;
      idx  = pos[dtps_pkg::POS_W-1:dtps_pkg::FRAC_W];
      nxt  = idx + 1'b1;
      frac = pos[dtps_pkg::FRAC_W-1:0];
      return (longint'(dtps_pkg::ONE_Q16) - longint'(frac)) * longint'(delay_mem[idx]) +
             longint'(frac) * longint'(delay_mem[nxt]);
   endfunction

   // advance the phase, read both taps, store the sample and mix
   function automatic dtps_pkg::sample_type shift_sample(input dtps_pkg::sample_type x);
      longint               rate, d0, d1, mid_offset, env0, env1, tap0, tap1, wet, acc, y;
      dtps_pkg::sample_type result;
      rate = longint'(dtps_pkg::ONE_Q16) - longint'(ratio_reg);
      d0   = longint'(phase_q16) + rate;
      if (d0 > dtps_pkg::PHASE_HIGH) d0 -= dtps_pkg::PHASE_SPAN;
      if (d0 < dtps_pkg::PHASE_LOW) d0 += dtps_pkg::PHASE_SPAN;
      phase_q16 = d0[dtps_pkg::PHASE_W-1:0];

      d1 = d0 + dtps_pkg::TAP_OFFSET;
      if (d1 > dtps_pkg::PHASE_HIGH) d1 -= dtps_pkg::PHASE_SPAN;
      if (d1 < dtps_pkg::PHASE_LOW) d1 += dtps_pkg::PHASE_SPAN;

      // triangular crossfade around the middle of the range
      mid_offset = d0 - dtps_pkg::PHASE_MID;
      if (mid_offset < 0) mid_offset = -mid_offset;
      env1 = mid_offset / ENV_SPAN;
      env0 = longint'(dtps_pkg::ONE_Q16) - env1;

      // taps read before the new sample goes in
      tap0 = tap_value(d0);
      tap1 = tap_value(d1);
      delay_mem[wr_ptr] = x;
      wr_ptr = wr_ptr + 1'b1;

      wet = (env0 * tap0 + env1 * tap1) >>> 16;
      acc = wet * longint'(mix_reg) +
            (longint'(dtps_pkg::ONE_Q16) - longint'(mix_reg)) *
            (longint'(x) * dtps_pkg::ONE_Q16);
      y = (acc + ROUND_HALF) >>> 32;
      if (y > SAT_HIGH) y = SAT_HIGH;
      if (y < SAT_LOW) y = SAT_LOW;
      result = y[dtps_pkg::SAMPLE_W-1:0];
      return result;
   endfunction

   always @(posedge clock) begin
      dtps_pkg::sample_type want;
      if (reset) begin
         foreach (delay_mem[i]) delay_mem[i] = '0;
         wr_ptr    = '0;
         phase_q16 = dtps_pkg::PHASE_W'(dtps_pkg::PHASE_LOW);
         ratio_reg = '0;
         mix_reg   = dtps_pkg::MIX_W'(dtps_pkg::MIX_RESET);
         owed_samples.delete();
      end else begin
         // register access phase
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if (reg_index == dtps_pkg::CSR_SHIFT_RATIO) begin
                  ratio_reg = csr_pwdata[dtps_pkg::RATIO_W-1:0];
                  if (ratio_reg == dtps_pkg::ONE_Q16)
                     phase_q16 = dtps_pkg::PHASE_W'(dtps_pkg::PHASE_MID);
               end else if (reg_index == dtps_pkg::CSR_EFFECT_MIX) begin
                  mix_reg = csr_pwdata[dtps_pkg::MIX_W-1:0];
               end
            end else begin
               if (reg_index == dtps_pkg::CSR_SHIFT_RATIO) begin
                  if (csr_prdata !== dtps_pkg::CSR_DW'(ratio_reg))
                     report_mismatch("shift_ratio read", longint'(csr_prdata),
                                     longint'(ratio_reg));
               end else if (reg_index == dtps_pkg::CSR_EFFECT_MIX) begin
                  if (csr_prdata !== dtps_pkg::CSR_DW'(mix_reg))
                     report_mismatch("effect_mix read", longint'(csr_prdata),
                                     longint'(mix_reg));
               end
            end
         end

         // input transfer
         if (req.valid && req.ready)
            owed_samples.push_back(shift_sample(req.sample_in));

         // result transfer
         if (rsp.valid && rsp.ready) begin
            if (owed_samples.size() == 0) begin
               report_mismatch("sample_out with nothing owed", longint'(rsp.sample_out), 0);
            end else begin
               want = owed_samples.pop_front();
               if (rsp.sample_out !== want)
                  report_mismatch("sample_out", longint'(rsp.sample_out), longint'(want));
            end
         end
      end
      pending <= owed_samples.size();
   end

endmodule

FILE: bench/tb_dual_tap_pitch_shifter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_tap_pitch_shifter
// Drives the pitch shifter with directed extremes and then random runs of
// audio samples under a series of ratio and mix settings, with random gaps
// on the input and random back-pressure on the output. Checking is done by
// dtps_sample_check; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_dual_tap_pitch_shifter;

   localparam int RANDOM_ITEMS = 1200;
   localparam int QUIET_ITEMS  = 100;
   localparam int DRAIN_CYCLES = 40;
   localparam int MAX_RATIO    = (1 << dtps_pkg::RATIO_W) - 1;
   localparam int MAX_MIX      = (1 << dtps_pkg::MIX_W) - 1;

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        csr_psel;
   logic                        csr_penable;
   logic                        csr_pwrite;
   logic [dtps_pkg::CSR_AW-1:0] csr_paddr;
   logic [dtps_pkg::CSR_DW-1:0] csr_pwdata;
   logic [dtps_pkg::CSR_DW-1:0] csr_prdata;
   logic                        csr_pready;

   int                          fail_count;
   int                          pending;
   int                          gap_pct   = 0;
   int                          stall_pct = 0;
   int                          sent      = 0;
   dtps_pkg::sample_type        script [$];

   dtps_req_if req_bus ();
   dtps_rsp_if rsp_bus ();

   dual_tap_pitch_shifter DUT (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   dtps_sample_check sample_check (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   always #5 clock = ~clock;

   // hard stop
   initial begin
      #5_000_000;
      $display("dual_tap_pitch_shifter regression: fail");
      $finish;
   end

   // result side back-pressure in bursts
   initial begin
      rsp_bus.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
      end
   end

   // register transfer: setup phase, access phase until ready, then idle
   task automatic csr_access(input logic idx, input logic write,
                             input logic [dtps_pkg::CSR_DW-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // write both registers with junk above the field, then read them back
   task automatic set_mode(input logic [dtps_pkg::RATIO_W-1:0] ratio,
                           input logic [dtps_pkg::MIX_W-1:0] mix);
      logic [dtps_pkg::CSR_DW-1:0] word;
      word = $urandom;
      word[dtps_pkg::RATIO_W-1:0] = ratio;
      csr_access(dtps_pkg::CSR_SHIFT_RATIO, 1'b1, word);
      word = $urandom;
      word[dtps_pkg::MIX_W-1:0] = mix;
      csr_access(dtps_pkg::CSR_EFFECT_MIX, 1'b1, word);
      csr_access(dtps_pkg::CSR_SHIFT_RATIO, 1'b0, '0);
      csr_access(dtps_pkg::CSR_EFFECT_MIX, 1'b0, '0);
   endtask

   // one input transfer, with an occasional gap ahead of it
   task automatic send_sample(input dtps_pkg::sample_type x);
      if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.sample_in <= x;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sent++;
   endtask

   // the block is idle once every owed sample has come back
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic send_script();
      foreach (script[i]) send_sample(script[i]);
      script.delete();
      wait_idle();
   endtask

   function automatic dtps_pkg::sample_type pick_sample();
      logic [31:0]          r;
      dtps_pkg::sample_type s;
      r = $urandom;
      case ($urandom_range(0, 9))
         0: s = r[0] ? 16'sh7fff : 16'sh8000;
         1: s = r[0] ? 16'sh0000 : 16'shffff;
         2, 3: s = dtps_pkg::sample_type'(r[7:0]) - 16'sd128;
         default: s = r[dtps_pkg::SAMPLE_W-1:0];
      endcase
      return s;
   endfunction

   task automatic send_random(input int count);
      repeat (count) send_sample(pick_sample());
      wait_idle();
   endtask

   function automatic logic [dtps_pkg::RATIO_W-1:0] pick_ratio();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(0, 5))
         0: r = 0;
         1: r = dtps_pkg::ONE_Q16;
         2: r = MAX_RATIO;
         // near unity, small pitch moves
         3: r = dtps_pkg::ONE_Q16 - 16384 + $urandom_range(0, 32768);
         4: r = $urandom_range(0, 2 * dtps_pkg::ONE_Q16);
         default: ;
      endcase
      return r[dtps_pkg::RATIO_W-1:0];
   endfunction

   function automatic logic [dtps_pkg::MIX_W-1:0] pick_mix();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(0, 5))
         0: r = 0;
         1: r = dtps_pkg::ONE_Q16;
         2: r = MAX_MIX;
         3, 4: r = $urandom_range(0, dtps_pkg::ONE_Q16);
         default: ;
      endcase
      return r[dtps_pkg::MIX_W-1:0];
   endfunction

   function automatic int pick_pct(input int a, input int b, input int c);
      case ($urandom_range(0, 3))
         0: return 0;
         1: return a;
         2: return b;
         default: return c;
      endcase
   endfunction

   // main sequence
   initial begin
      reset             <= 1'b1;
      csr_psel          <= 1'b0;
      csr_penable       <= 1'b0;
      csr_pwrite        <= 1'b0;
      csr_paddr         <= '0;
      csr_pwdata        <= '0;
      req_bus.valid     <= 1'b0;
      req_bus.sample_in <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // registers read back at their reset values
      csr_access(dtps_pkg::CSR_SHIFT_RATIO, 1'b0, '0);
      csr_access(dtps_pkg::CSR_EFFECT_MIX, 1'b0, '0);

      // reset settings, full-scale steps
      script = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff, 16'sh0001,
                 16'sh7fff, 16'sh7fff, 16'sh8000};
      send_script();

      // ratio of exactly one pins the phase to the middle, fully wet
      set_mode(dtps_pkg::RATIO_W'(dtps_pkg::ONE_Q16), dtps_pkg::MIX_W'(dtps_pkg::ONE_Q16));
      script = '{16'sh7fff, 16'sh8000, 16'sh3039, 16'shffff};
      send_script();

      // largest ratio with mix above one, output saturates
      set_mode(dtps_pkg::RATIO_W'(MAX_RATIO), dtps_pkg::MIX_W'(MAX_MIX));
      script = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh0000};
      send_script();

      // dry only
      set_mode('0, '0);
      script = '{16'sh8000, 16'sh7fff};
      send_script();

      // rate of minus one, three-quarter wet
      set_mode(dtps_pkg::RATIO_W'(2 * dtps_pkg::ONE_Q16), dtps_pkg::MIX_W'(49152));
      script = '{16'sh5a5a, 16'sha5a5, 16'sh00ff, 16'shff00};
      send_script();

      // random runs, each under its own settings and idling mix
      while (sent < RANDOM_ITEMS) begin
         gap_pct   = pick_pct(10, 30, 60);
         stall_pct = pick_pct(5, 15, 30);
         set_mode(pick_ratio(), pick_mix());
         send_random($urandom_range(60, 160));
      end

      // closing run at full rate
      gap_pct   = 0;
      stall_pct = 0;
      set_mode(pick_ratio(), pick_mix());
      send_random(QUIET_ITEMS);

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("dual_tap_pitch_shifter regression: pass");
      else
         $display("dual_tap_pitch_shifter regression: fail");
      $finish;
   end

endmodule
